### sv/kmde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key matrix debounce package
// Shared types and constants for the key matrix debounce and event block.
// ----------------------------------------------------------------------------

package kmde_pkg;

  // Width of one raw matrix sample on the input channel.
  localparam int SAMPLE_W = 12;

  // Width of the row, column and kind fields on the output channel.
  localparam int FIELD_W = 2;

  // Kind of a key event.
  typedef enum logic [1:0] {
    KIND_PRESSED  = 2'd0,
    KIND_RELEASED = 2'd1,
    KIND_HELD     = 2'd2
  } event_kind_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEB,
    ST_DEB_DONE,
    ST_WALK,
    ST_WALK_DONE,
    ST_CHK_RD,
    ST_CHK_EV,
    ST_EMIT_RD,
    ST_EMIT_LD
  } seq_state_e;

  // Control of the sample history shift line.
  typedef struct packed {
    logic shift;  // move every slot one place toward the head
    logic load;   // fill the tail with the new sample instead of the head
  } hist_ctrl_t;

endpackage

`default_nettype wire

### sv/kmde_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key matrix debounce channel interfaces
// Valid/ready channels for raw matrix samples and for key events.
// ----------------------------------------------------------------------------

// Raw matrix sample channel.
interface kmde_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] matrix_sample;

  modport source (output valid, output matrix_sample, input ready);
  modport sink (input valid, input matrix_sample, output ready);
endinterface

// Key event channel.
interface kmde_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] key_row;
  logic [1:0] key_col;
  logic [1:0] event_kind;
  logic       last_event;

  modport source (output valid, output key_row, output key_col, output event_kind,
                  output last_event, input ready);
  modport sink (input valid, input key_row, input key_col, input event_kind,
                input last_event, output ready);
endinterface

`default_nettype wire

### sv/kmde_history.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample history shift line
// Holds the last SCAN_DEPTH samples with the oldest at the head. The head
// pair feeds the shared equality comparator used for debouncing; rotating
// the line walks the comparator over all adjacent pairs.
// ----------------------------------------------------------------------------

module kmde_history import kmde_pkg::*; #(
  parameter int ROWS       = 4,
  parameter int COLS       = 3,
  parameter int SCAN_DEPTH = 4
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire hist_ctrl_t             ctrl_i,
  input  wire logic [SAMPLE_W-1:0]    sample_i,
  output logic      [ROWS*COLS-1:0]   head_o,
  output logic                        head_eq_o
);

  localparam int MW = ROWS * COLS;

  logic [MW-1:0] taps_q [SCAN_DEPTH];
  logic [MW-1:0] tail_d;

  // Bits beyond the matrix are dropped, missing bits read as zero.
  assign tail_d = ctrl_i.load ? MW'(sample_i) : taps_q[0];

  // Shift toward the head; the tail takes a new sample or the old head.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SCAN_DEPTH; k++) begin
        taps_q[k] <= '0;
      end
    end else if (ctrl_i.shift) begin
      for (int k = 0; k < SCAN_DEPTH - 1; k++) begin
        taps_q[k] <= taps_q[k + 1];
      end
      taps_q[SCAN_DEPTH - 1] <= tail_d;
    end
  end

  // Shared comparator on the head pair.
  assign head_o    = taps_q[0];
  assign head_eq_o = (taps_q[0] == taps_q[1]);

endmodule

`default_nettype wire

### sv/kmde_evbuf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event buffer
// One write port and one registered read port holding the locations and
// kinds of the events of the current evaluation.
// ----------------------------------------------------------------------------

module kmde_evbuf #(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int EW    = 6
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [EW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [EW-1:0] rdata_o
);

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/kmde_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key matrix debounce sequencer
// Counts scans, steps the history comparator over the adjacent pairs, walks
// the keys one per cycle to build the event list, checks for ghosting when at
// least four events were found and plays the events out via the output register.
// ----------------------------------------------------------------------------

module kmde_seq import kmde_pkg::*; #(
  parameter int ROWS       = 4,
  parameter int COLS       = 3,
  parameter int SCAN_DEPTH = 4,
  parameter int MAX_EVENTS = 8,
  localparam int MW = ROWS * COLS,
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1,
  localparam int AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1,
  localparam int EW = RW + CW + 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Sample channel handshake
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  // History shift line
  output hist_ctrl_t              hist_ctrl_o,
  input  wire logic [MW-1:0]      hist_head_i,
  input  wire logic               hist_eq_i,
  // Event buffer
  output logic                    buf_we_o,
  output logic      [AW-1:0]      buf_waddr_o,
  output logic      [EW-1:0]      buf_wdata_o,
  output logic                    buf_re_o,
  output logic      [AW-1:0]      buf_raddr_o,
  input  wire logic [EW-1:0]      buf_rdata_i,
  // Event channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [FIELD_W-1:0] key_row_o,
  output logic      [FIELD_W-1:0] key_col_o,
  output logic      [FIELD_W-1:0] event_kind_o,
  output logic                    last_event_o
);

  localparam int PW         = (MW > 1) ? $clog2(MW) : 1;
  localparam int DW         = $clog2(SCAN_DEPTH);
  localparam int NW         = $clog2(MAX_EVENTS + 1);
  localparam int DIFF_LIMIT = SCAN_DEPTH / 2 + 1;

  seq_state_e state_q, state_d;

  logic [DW-1:0] slot_q;
  logic [DW-1:0] step_q;
  logic [DW-1:0] differ_q;
  logic          found_q;
  logic [MW-1:0] now_q;
  logic [MW-1:0] prev_q;
  logic [RW-1:0] r_q;
  logic [CW-1:0] c_q;
  logic [PW-1:0] pos_q;
  logic [PW-1:0] base_q;
  logic          held_q;
  logic [NW-1:0] n_q;
  logic [NW-1:0] k_q;
  logic [1:0]    row_cnt_q [ROWS];
  logic [1:0]    col_cnt_q [COLS];

  logic               out_valid_q;
  logic [FIELD_W-1:0] key_row_q;
  logic [FIELD_W-1:0] key_col_q;
  logic [FIELD_W-1:0] event_kind_q;
  logic               last_event_q;

  logic        accept;
  logic        slot_last;
  logic        step_last;
  logic        deb_fail;
  logic        bit_now;
  logic        bit_old;
  logic        hit;
  logic        ev_full;
  logic        col_last;
  logic        row_last;
  logic        walk_end;
  logic        k_last;
  logic        many_events;
  logic        clash_hit;
  logic        out_free;
  logic        load_out;
  event_kind_e kind;
  logic [RW-1:0] rd_row;
  logic [CW-1:0] rd_col;
  logic [1:0]    rd_kind;

  // Status decode shared by the next-state and output logic.
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign slot_last   = (slot_q == DW'(SCAN_DEPTH - 1));
  assign step_last   = (step_q == DW'(SCAN_DEPTH - 2));
  assign deb_fail    = (32'(differ_q) > DIFF_LIMIT) || !found_q;
  assign bit_now     = now_q[pos_q];
  assign bit_old     = prev_q[pos_q];
  assign hit         = held_q ? (bit_now & bit_old) : (bit_now ^ bit_old);
  assign ev_full     = (n_q == NW'(MAX_EVENTS));
  assign col_last    = (c_q == CW'(COLS - 1));
  assign row_last    = (r_q == RW'(ROWS - 1));
  assign walk_end    = (hit && ev_full) || (col_last && held_q && row_last);
  assign k_last      = (k_q == (n_q - NW'(1)));
  assign many_events = (32'(n_q) >= 32'd4);
  assign out_free    = !out_valid_q || out_ready_i;

  // Fields of the event read back from the buffer.
  assign rd_row  = buf_rdata_i[EW-1 -: RW];
  assign rd_col  = buf_rdata_i[2 +: CW];
  assign rd_kind = buf_rdata_i[1:0];

  // A key whose row and column are both shared with other events is a clash.
  assign clash_hit = row_cnt_q[rd_row][1] && col_cnt_q[rd_col][1];

  assign kind = held_q ? KIND_HELD : (bit_now ? KIND_PRESSED : KIND_RELEASED);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && slot_last) begin
          state_d = ST_DEB;
        end
      end
      ST_DEB: begin
        if (step_last) begin
          state_d = ST_DEB_DONE;
        end
      end
      ST_DEB_DONE: begin
        state_d = deb_fail ? ST_IDLE : ST_WALK;
      end
      ST_WALK: begin
        if (walk_end) begin
          state_d = ST_WALK_DONE;
        end
      end
      ST_WALK_DONE: begin
        if (n_q == '0) begin
          state_d = ST_IDLE;
        end else if (many_events) begin
          state_d = ST_CHK_RD;
        end else begin
          state_d = ST_EMIT_RD;
        end
      end
      ST_CHK_RD: begin
        state_d = ST_CHK_EV;
      end
      ST_CHK_EV: begin
        if (clash_hit) begin
          state_d = ST_IDLE;
        end else if (k_last) begin
          state_d = ST_EMIT_RD;
        end else begin
          state_d = ST_CHK_RD;
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (out_free) begin
          state_d = k_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready_o        = (state_q == ST_IDLE);
    hist_ctrl_o.shift = accept || (state_q == ST_DEB);
    hist_ctrl_o.load  = accept;
    buf_we_o          = (state_q == ST_WALK) && hit && !ev_full;
    buf_re_o          = (state_q == ST_CHK_RD) || (state_q == ST_EMIT_RD);
    load_out          = (state_q == ST_EMIT_LD) && out_free;
  end

  assign buf_waddr_o = n_q[AW-1:0];
  assign buf_wdata_o = {r_q, c_q, kind};
  assign buf_raddr_o = k_q[AW-1:0];

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      slot_q   <= '0;
      step_q   <= '0;
      differ_q <= '0;
      found_q  <= 1'b0;
      prev_q   <= '0;
      r_q      <= '0;
      c_q      <= '0;
      pos_q    <= '0;
      base_q   <= '0;
      held_q   <= 1'b0;
      n_q      <= '0;
      k_q      <= '0;
      for (int i = 0; i < ROWS; i++) begin
        row_cnt_q[i] <= '0;
      end
      for (int i = 0; i < COLS; i++) begin
        col_cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;

      // Scan slot counter and start of the pair comparison.
      if (accept) begin
        slot_q <= slot_last ? '0 : slot_q + DW'(1);
        if (slot_last) begin
          step_q   <= '0;
          differ_q <= '0;
          found_q  <= 1'b0;
        end
      end

      // One adjacent pair per cycle.
      if (state_q == ST_DEB) begin
        step_q <= step_q + DW'(1);
        if (hist_eq_i) begin
          found_q <= 1'b1;
        end else begin
          differ_q <= differ_q + DW'(1);
        end
      end

      // Set up the key walk.
      if ((state_q == ST_DEB_DONE) && !deb_fail) begin
        r_q    <= '0;
        c_q    <= '0;
        pos_q  <= '0;
        base_q <= '0;
        held_q <= 1'b0;
        n_q    <= '0;
        for (int i = 0; i < ROWS; i++) begin
          row_cnt_q[i] <= '0;
        end
        for (int i = 0; i < COLS; i++) begin
          col_cnt_q[i] <= '0;
        end
      end

      // One key per cycle: record the event and advance the position.
      if ((state_q == ST_WALK) && !walk_end) begin
        if (buf_we_o) begin
          n_q <= n_q + NW'(1);
          row_cnt_q[r_q] <= {row_cnt_q[r_q][1] | row_cnt_q[r_q][0],
                             ~row_cnt_q[r_q][1] & ~row_cnt_q[r_q][0]};
          col_cnt_q[c_q] <= {col_cnt_q[c_q][1] | col_cnt_q[c_q][0],
                             ~col_cnt_q[c_q][1] & ~col_cnt_q[c_q][0]};
        end
        if (col_last) begin
          c_q <= '0;
          if (!held_q) begin
            held_q <= 1'b1;
            pos_q  <= base_q;
          end else begin
            held_q <= 1'b0;
            r_q    <= r_q + RW'(1);
            base_q <= base_q + PW'(COLS);
            pos_q  <= base_q + PW'(COLS);
          end
        end else begin
          c_q   <= c_q + CW'(1);
          pos_q <= pos_q + PW'(1);
        end
      end

      // The last event can still be written on the cycle the walk ends.
      if ((state_q == ST_WALK) && walk_end && buf_we_o) begin
        n_q <= n_q + NW'(1);
        row_cnt_q[r_q] <= {row_cnt_q[r_q][1] | row_cnt_q[r_q][0],
                           ~row_cnt_q[r_q][1] & ~row_cnt_q[r_q][0]};
        col_cnt_q[c_q] <= {col_cnt_q[c_q][1] | col_cnt_q[c_q][0],
                           ~col_cnt_q[c_q][1] & ~col_cnt_q[c_q][0]};
      end

      // The whole stable matrix becomes the reference for the next time.
      if (state_q == ST_WALK_DONE) begin
        prev_q <= now_q;
        k_q    <= '0;
      end

      if (state_q == ST_CHK_EV) begin
        k_q <= k_last ? '0 : k_q + NW'(1);
      end

      if (load_out) begin
        k_q <= k_q + NW'(1);
      end
    end
  end

  // Stable matrix: the earlier sample of the latest agreeing pair.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DEB) && hist_eq_i) begin
      now_q <= hist_head_i;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      key_row_q    <= FIELD_W'(rd_row);
      key_col_q    <= FIELD_W'(rd_col);
      event_kind_q <= rd_kind;
      last_event_q <= k_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign key_row_o    = key_row_q;
  assign key_col_o    = key_col_q;
  assign event_kind_o = event_kind_q;
  assign last_event_o = last_event_q;

`ifndef SYNTHESIS
  // The event count never passes the cap.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(n_q) <= MAX_EVENTS)
    else $error("event count exceeds the cap");

  // Events are only read back for output when some exist and within the list.
  a_read_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_RD) |-> ((n_q != '0) && (k_q < n_q)))
    else $error("event read outside the list");

  // The pair comparison stops after the last adjacent pair.
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DEB) |-> (32'(step_q) <= SCAN_DEPTH - 2))
    else $error("pair step out of range");

  // The reference matrix follows the stable matrix after each walk.
  a_prev_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK_DONE) |=> (prev_q == $past(now_q)))
    else $error("reference matrix not updated");
`endif

endmodule

`default_nettype wire

### sv/key_matrix_debounce_events.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key matrix debounce and event generator
// Debounces ROWS x COLS key matrix samples over a ring of SCAN_DEPTH scans
// and reports pressed, released and held keys as a stream of events.
// ----------------------------------------------------------------------------
// A sample that does not complete a group of SCAN_DEPTH scans is taken and
// the block stays ready. The sample that completes a group starts an
// evaluation during which no sample is taken: the pair comparison on the
// single pair comparator of the history, a decision, a walk over the keys
// (each key twice, for changes and for held keys) one per cycle, which the
// event cap may cut short, the close of the walk, a ghost check on the event
// buffer read port when n >= 4 events were found, and the play-out of the
// events, which the event sink can stall. The last event may wait in the
// output register while the next sample is accepted.
// ----------------------------------------------------------------------------

module key_matrix_debounce_events import kmde_pkg::*; #(
  parameter int ROWS       = 4,
  parameter int COLS       = 3,
  parameter int SCAN_DEPTH = 4,
  parameter int MAX_EVENTS = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  kmde_in_if.sink     sample_i,
  kmde_out_if.source  event_o
);

  localparam int MW = ROWS * COLS;
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int EW = RW + CW + 2;

  hist_ctrl_t    hist_ctrl;
  logic [MW-1:0] hist_head;
  logic          hist_eq;
  logic          buf_we;
  logic [AW-1:0] buf_waddr;
  logic [EW-1:0] buf_wdata;
  logic          buf_re;
  logic [AW-1:0] buf_raddr;
  logic [EW-1:0] buf_rdata;

  // Sample history with the shared pair comparator.
  kmde_history #(
    .ROWS       (ROWS),
    .COLS       (COLS),
    .SCAN_DEPTH (SCAN_DEPTH)
  ) u_history (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (hist_ctrl),
    .sample_i  (sample_i.matrix_sample),
    .head_o    (hist_head),
    .head_eq_o (hist_eq)
  );

  // Event list storage.
  kmde_evbuf #(
    .DEPTH (MAX_EVENTS),
    .AW    (AW),
    .EW    (EW)
  ) u_evbuf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .re_i    (buf_re),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  // Sequencer and output register.
  kmde_seq #(
    .ROWS       (ROWS),
    .COLS       (COLS),
    .SCAN_DEPTH (SCAN_DEPTH),
    .MAX_EVENTS (MAX_EVENTS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (sample_i.valid),
    .in_ready_o   (sample_i.ready),
    .hist_ctrl_o  (hist_ctrl),
    .hist_head_i  (hist_head),
    .hist_eq_i    (hist_eq),
    .buf_we_o     (buf_we),
    .buf_waddr_o  (buf_waddr),
    .buf_wdata_o  (buf_wdata),
    .buf_re_o     (buf_re),
    .buf_raddr_o  (buf_raddr),
    .buf_rdata_i  (buf_rdata),
    .out_valid_o  (event_o.valid),
    .out_ready_i  (event_o.ready),
    .key_row_o    (event_o.key_row),
    .key_col_o    (event_o.key_col),
    .event_kind_o (event_o.event_kind),
    .last_event_o (event_o.last_event)
  );

endmodule

`default_nettype wire
